/* rtl/gbec_pkg.sv */
// Shared constants and codes for the greedy bitmask element coloring core.
package gbec_pkg;

    localparam int NODE_COUNT_DEF = 4096;
    localparam int REFS_DEF       = 4;
    localparam int MASK_BITS_DEF  = 32;

    localparam int NODE_W      = 12;
    localparam int COLOR_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int COLOR_LIMIT = 1024;
    localparam int FIELD_REFS  = 4;
    localparam int REF_W       = 2;
    localparam int NODE_ADDR_W = $clog2(NODE_COUNT_DEF);

    typedef enum logic [1:0] {
        ACT_COLOR = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_PASS  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_COLORED  = 2'd0,
        ST_OUT      = 2'd1,
        ST_NONCOLOR = 2'd2
    } t_status;

endpackage

/* rtl/gbec_mask_mem.sv */
// Node mask memory: one write port, one read port, registered read data.
module gbec_mask_mem #(
    parameter int DEPTH  = gbec_pkg::NODE_COUNT_DEF,
    parameter int WIDTH  = gbec_pkg::MASK_BITS_DEF,
    parameter int ADDR_W = gbec_pkg::NODE_ADDR_W
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/greedy_bitmask_element_coloring_core.sv */
// Top level: sequencer around the node mask memory for greedy element coloring.
//
// Input channel (i_valid / o_ready) takes one request: an action and four node
// references with use flags. Output channel (o_valid / i_ready) returns one
// result per request: status, color and the running color count.
//
// One request is processed at a time. A color request is accepted, reads the mask
// of each of its R = min(REFS_PER_ELEMENT, 4) references, waits for the read
// data, picks the lowest free bit, writes the mask of each flagged reference back
// and loads the result; when out of colors it skips the writes. A clear request
// clears the mask of each flagged reference; a new pass or an unused action goes
// straight to the result load. When NODE_COUNT is below 4096 and not a power of
// two, a reciprocal multiply (quotient, then remainder) reduces the addresses
// modulo NODE_COUNT before the reads of a color or the writes of a clear request.
//
// After reset the block clears the mask memory, one entry per cycle, through
// all NODE_COUNT entries; o_ready stays low until that is done. Results sit in an
// output register: the next request is accepted while a result waits, and
// that request's result holds inside until the output register frees up.
module greedy_bitmask_element_coloring_core #(
    parameter int NODE_COUNT       = gbec_pkg::NODE_COUNT_DEF,
    parameter int REFS_PER_ELEMENT = gbec_pkg::REFS_DEF,
    parameter int MASK_BITS        = gbec_pkg::MASK_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_action,
    input  logic [gbec_pkg::NODE_W-1:0]  i_node_0,
    input  logic [gbec_pkg::NODE_W-1:0]  i_node_1,
    input  logic [gbec_pkg::NODE_W-1:0]  i_node_2,
    input  logic [gbec_pkg::NODE_W-1:0]  i_node_3,
    input  logic                         i_use_0,
    input  logic                         i_use_1,
    input  logic                         i_use_2,
    input  logic                         i_use_3,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_status,
    output logic [gbec_pkg::COLOR_W-1:0] o_color,
    output logic [gbec_pkg::COUNT_W-1:0] o_color_count
);

    localparam int ADDR_W    = $clog2(NODE_COUNT);
    localparam int BIT_W     = $clog2(MASK_BITS);
    localparam int REFS_USED = (REFS_PER_ELEMENT < gbec_pkg::FIELD_REFS) ?
                               REFS_PER_ELEMENT : gbec_pkg::FIELD_REFS;
    localparam int TOP_BASE  = gbec_pkg::COLOR_LIMIT - MASK_BITS;
    localparam bit MOD_NEEDED = (NODE_COUNT < (1 << gbec_pkg::NODE_W)) &&
                                ((NODE_COUNT & (NODE_COUNT - 1)) != 0);
    // reciprocal of NODE_COUNT, exact for every 12-bit address
    localparam int MOD_SH    = gbec_pkg::NODE_W + ADDR_W;
    localparam int PROD_W    = MOD_SH + gbec_pkg::NODE_W + 1;
    localparam logic [PROD_W-1:0] MOD_M =
        PROD_W'(((64'd1 << MOD_SH) + 64'(NODE_COUNT) - 64'd1) / 64'(NODE_COUNT));
    localparam logic [gbec_pkg::NODE_W-1:0]     MOD_N    = gbec_pkg::NODE_W'(NODE_COUNT);
    localparam logic [ADDR_W-1:0]               INIT_END = ADDR_W'(NODE_COUNT - 1);
    localparam logic [gbec_pkg::REF_W-1:0]      REF_LAST = gbec_pkg::REF_W'(REFS_USED - 1);
    localparam logic                            MOD_LAST = 1'b1;
    localparam logic [gbec_pkg::COLOR_W-1:0]    TOP_B    = gbec_pkg::COLOR_W'(TOP_BASE);
    localparam logic [gbec_pkg::COUNT_W-1:0]    STEP     = gbec_pkg::COUNT_W'(MASK_BITS);

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MOD   = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_WAIT  = 8'b0001_0000,
        S_FIND  = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [ADDR_W-1:0]            r_init;
    logic [gbec_pkg::REF_W-1:0]   r_k;
    logic                         r_mcnt;
    logic                         r_rd_pend;
    logic [gbec_pkg::REF_W-1:0]   r_rd_k;
    logic                         r_out_valid;
    logic [gbec_pkg::COLOR_W-1:0] r_base;
    logic [gbec_pkg::COUNT_W-1:0] r_colors;

    logic                         r_clr;
    logic [gbec_pkg::NODE_W-1:0]  r_node [gbec_pkg::FIELD_REFS];
    logic [gbec_pkg::NODE_W-1:0]  r_quot [gbec_pkg::FIELD_REFS];
    logic [ADDR_W-1:0]            r_idx  [gbec_pkg::FIELD_REFS];
    logic                         r_flag [gbec_pkg::FIELD_REFS];
    logic [MASK_BITS-1:0]         r_old  [gbec_pkg::FIELD_REFS];
    logic [MASK_BITS-1:0]         r_used;
    logic [MASK_BITS-1:0]         r_sel;
    logic [1:0]                   r_res_status;
    logic [gbec_pkg::COLOR_W-1:0] r_res_color;
    logic [1:0]                   r_o_status;
    logic [gbec_pkg::COLOR_W-1:0] r_o_color;
    logic [gbec_pkg::COUNT_W-1:0] r_o_count;

    logic [gbec_pkg::NODE_W-1:0]  in_node [gbec_pkg::FIELD_REFS];
    logic                         in_use  [gbec_pkg::FIELD_REFS];

    logic                         accept;
    logic                         publish;
    logic [MASK_BITS-1:0]         free_bits;
    logic [MASK_BITS-1:0]         low_bit;
    logic [BIT_W-1:0]             bit_idx;
    logic [gbec_pkg::COLOR_W-1:0] new_color;
    logic [gbec_pkg::COUNT_W-1:0] new_count;

    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_waddr;
    logic [MASK_BITS-1:0]         mem_wdata;
    logic [MASK_BITS-1:0]         mem_rdata;

    assign in_node[0] = i_node_0;
    assign in_node[1] = i_node_1;
    assign in_node[2] = i_node_2;
    assign in_node[3] = i_node_3;
    assign in_use[0]  = i_use_0;
    assign in_use[1]  = i_use_1;
    assign in_use[2]  = i_use_2;
    assign in_use[3]  = i_use_3;

    assign accept  = i_valid && o_ready;
    assign publish = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // lowest free color: isolate the lowest set bit, then encode it
    always_comb begin
        free_bits = ~r_used;
        low_bit   = free_bits & (~free_bits + MASK_BITS'(1));
        bit_idx   = '0;
        for (int b = 0; b < MASK_BITS; b++) begin
            if (low_bit[b]) begin
                bit_idx = bit_idx | BIT_W'(b);
            end
        end
        new_color = r_base + gbec_pkg::COLOR_W'(bit_idx);
        new_count = {1'b0, new_color} + gbec_pkg::COUNT_W'(1);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_init == INIT_END) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    priority if (i_action == gbec_pkg::ACT_COLOR ||
                                 i_action == gbec_pkg::ACT_CLEAR) begin
                        if (MOD_NEEDED)                           n_state = S_MOD;
                        else if (i_action == gbec_pkg::ACT_COLOR) n_state = S_READ;
                        else                                      n_state = S_WRITE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MOD: begin
                if (r_mcnt == MOD_LAST) begin
                    n_state = r_clr ? S_WRITE : S_READ;
                end
            end
            S_READ: begin
                if (r_k == REF_LAST) n_state = S_WAIT;
            end
            S_WAIT: n_state = S_FIND;
            S_FIND: n_state = (free_bits == '0) ? S_DONE : S_WRITE;
            S_WRITE: begin
                if (r_k == REF_LAST) n_state = S_DONE;
            end
            S_DONE: begin
                if (publish) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init      <= '0;
            r_k         <= '0;
            r_mcnt      <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_base      <= '0;
            r_colors    <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= (r_state == S_READ);
            if (r_state == S_INIT) r_init <= r_init + ADDR_W'(1);
            if (r_state == S_MOD) r_mcnt <= r_mcnt + 1'b1;
            else                  r_mcnt <= 1'b0;
            if (r_state == S_READ || r_state == S_WRITE) begin
                r_k <= (r_k == REF_LAST) ? '0 : r_k + gbec_pkg::REF_W'(1);
            end else begin
                r_k <= '0;
            end
            if (accept && i_action == gbec_pkg::ACT_PASS) begin
                if ({1'b0, r_base} + STEP <= {1'b0, TOP_B}) begin
                    r_base <= r_base + gbec_pkg::COLOR_W'(MASK_BITS);
                end else begin
                    r_base <= TOP_B;
                end
            end
            if (r_state == S_FIND && free_bits != '0 && new_count > r_colors) begin
                r_colors <= new_count;
            end
            if (publish)      r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    // request payload and working values
    always_ff @(posedge i_clk) begin
        r_rd_k <= r_k;
        if (accept) begin
            r_clr        <= (i_action == gbec_pkg::ACT_CLEAR);
            r_used       <= '0;
            r_res_status <= gbec_pkg::ST_NONCOLOR;
            r_res_color  <= '0;
            for (int k = 0; k < gbec_pkg::FIELD_REFS; k++) begin
                r_node[k] <= in_node[k];
                r_flag[k] <= in_use[k] && (k < REFS_USED);
                r_idx[k]  <= MOD_NEEDED ? '0 : ADDR_W'(in_node[k]);
            end
        end
        // r_mcnt low: quotient by reciprocal; r_mcnt high: address minus quotient times N
        if (r_state == S_MOD) begin
            for (int k = 0; k < gbec_pkg::FIELD_REFS; k++) begin
                if (!r_mcnt) begin
                    r_quot[k] <= gbec_pkg::NODE_W'((PROD_W'(r_node[k]) * MOD_M) >> MOD_SH);
                end else begin
                    r_idx[k] <= ADDR_W'(r_node[k] -
                                        gbec_pkg::NODE_W'(r_quot[k] * MOD_N));
                end
            end
        end
        if (r_rd_pend) begin
            r_old[r_rd_k] <= mem_rdata;
            if (r_flag[r_rd_k]) r_used <= r_used | mem_rdata;
        end
        if (r_state == S_FIND) begin
            r_sel <= low_bit;
            if (free_bits == '0) begin
                r_res_status <= gbec_pkg::ST_OUT;
            end else begin
                r_res_status <= gbec_pkg::ST_COLORED;
                r_res_color  <= new_color;
            end
        end
        if (publish) begin
            r_o_status <= r_res_status;
            r_o_color  <= r_res_color;
            r_o_count  <= r_colors;
        end
    end

    always_comb begin
        priority if (r_state == S_INIT) begin
            mem_we    = 1'b1;
            mem_waddr = r_init;
            mem_wdata = '0;
        end else begin
            mem_we    = (r_state == S_WRITE) && r_flag[r_k];
            mem_waddr = r_idx[r_k];
            mem_wdata = r_clr ? '0 : (r_old[r_k] | r_sel);
        end
    end

    gbec_mask_mem #(
        .DEPTH  (NODE_COUNT),
        .WIDTH  (MASK_BITS),
        .ADDR_W (ADDR_W)
    ) u_mask_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx[r_k]),
        .o_rdata (mem_rdata)
    );

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_o_status;
    assign o_color       = r_o_color;
    assign o_color_count = r_o_count;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("request accepted while another is in flight");

    a_color_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == gbec_pkg::ST_COLORED) |->
        ({1'b0, o_color} < o_color_count))
        else $error("color not covered by color count");

    a_color_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != gbec_pkg::ST_COLORED) |-> (o_color == '0))
        else $error("color nonzero on uncolored result");

    a_base_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base <= TOP_B)
        else $error("pass base above top");

    a_no_write_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_WAIT) |-> !mem_we)
        else $error("mask write during read phase");

endmodule

/* verif/tb_top.sv */
// Testbench for the greedy bitmask element coloring core: driver, monitor and predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int ITEMS        = 1550;
    localparam int LIMIT_CYCLES = 800000;
    localparam int TAIL_CYCLES  = 40;
    localparam int TOP_BASE     = gbec_pkg::COLOR_LIMIT - gbec_pkg::MASK_BITS_DEF;
    localparam int POOL_SIZE    = 16;

    typedef struct packed {
        gbec_pkg::t_action                                   action;
        logic [gbec_pkg::FIELD_REFS-1:0][gbec_pkg::NODE_W-1:0] node;
        logic [gbec_pkg::FIELD_REFS-1:0]                     flag;
    } t_elem_req;

    typedef struct packed {
        gbec_pkg::t_status            status;
        logic [gbec_pkg::COLOR_W-1:0] color;
        logic [gbec_pkg::COUNT_W-1:0] count;
    } t_color_result;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [1:0]                   i_action;
    logic [gbec_pkg::NODE_W-1:0]  i_node_0;
    logic [gbec_pkg::NODE_W-1:0]  i_node_1;
    logic [gbec_pkg::NODE_W-1:0]  i_node_2;
    logic [gbec_pkg::NODE_W-1:0]  i_node_3;
    logic                         i_use_0;
    logic                         i_use_1;
    logic                         i_use_2;
    logic                         i_use_3;
    logic                         o_valid;
    logic                         i_ready;
    logic [1:0]                   o_status;
    logic [gbec_pkg::COLOR_W-1:0] o_color;
    logic [gbec_pkg::COUNT_W-1:0] o_color_count;

    // predictor state
    logic [gbec_pkg::MASK_BITS_DEF-1:0] node_mask [gbec_pkg::NODE_COUNT_DEF];
    logic [gbec_pkg::COLOR_W-1:0]       pass_base;
    logic [gbec_pkg::COUNT_W-1:0]       colors_used;

    t_elem_req     elem_q [$];
    t_color_result color_exp_q [$];
    t_elem_req     cur_req;
    logic [gbec_pkg::NODE_W-1:0] node_pool [POOL_SIZE];

    int n_sent;
    int n_total;
    int n_err;
    int idle_phase;
    int cycles;

    greedy_bitmask_element_coloring_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_node_0      (i_node_0),
        .i_node_1      (i_node_1),
        .i_node_2      (i_node_2),
        .i_node_3      (i_node_3),
        .i_use_0       (i_use_0),
        .i_use_1       (i_use_1),
        .i_use_2       (i_use_2),
        .i_use_3       (i_use_3),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_color       (o_color),
        .o_color_count (o_color_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Applies one request to the predictor state and returns its result.
    function automatic t_color_result predict_coloring(input t_elem_req r);
        logic [gbec_pkg::MASK_BITS_DEF-1:0] taken;
        logic [gbec_pkg::MASK_BITS_DEF-1:0] pick;
        int                                 bit_i;
        int                                 k;
        t_color_result                      res;
        taken = '0;
        res.status = gbec_pkg::ST_NONCOLOR;
        res.color  = '0;
        case (r.action)
            gbec_pkg::ACT_COLOR: begin
                for (k = 0; k < gbec_pkg::FIELD_REFS; k++)
                    if (r.flag[k])
                        taken |= node_mask[r.node[k] % gbec_pkg::NODE_COUNT_DEF];
                if (&taken) begin
                    res.status = gbec_pkg::ST_OUT;
                end else begin
                    bit_i = 0;
                    while (taken[bit_i]) bit_i++;
                    pick = '0;
                    pick[bit_i] = 1'b1;
                    for (k = 0; k < gbec_pkg::FIELD_REFS; k++)
                        if (r.flag[k])
                            node_mask[r.node[k] % gbec_pkg::NODE_COUNT_DEF] |= pick;
                    res.color = gbec_pkg::COLOR_W'(pass_base + bit_i);
                    if (res.color + 1 > colors_used)
                        colors_used = gbec_pkg::COUNT_W'(res.color + 1);
                    res.status = gbec_pkg::ST_COLORED;
                end
            end
            gbec_pkg::ACT_CLEAR: begin
                for (k = 0; k < gbec_pkg::FIELD_REFS; k++)
                    if (r.flag[k]) node_mask[r.node[k] % gbec_pkg::NODE_COUNT_DEF] = '0;
            end
            gbec_pkg::ACT_PASS: begin
                // base saturates so every color still fits in 10 bits
                if (pass_base + gbec_pkg::MASK_BITS_DEF <= TOP_BASE)
                    pass_base = gbec_pkg::COLOR_W'(pass_base + gbec_pkg::MASK_BITS_DEF);
                else
                    pass_base = gbec_pkg::COLOR_W'(TOP_BASE);
            end
            default: ;
        endcase
        res.count = colors_used;
        return res;
    endfunction

    task automatic queue_req(input gbec_pkg::t_action act,
                             input logic [gbec_pkg::NODE_W-1:0] n0,
                             input logic [gbec_pkg::NODE_W-1:0] n1,
                             input logic [gbec_pkg::NODE_W-1:0] n2,
                             input logic [gbec_pkg::NODE_W-1:0] n3,
                             input logic [gbec_pkg::FIELD_REFS-1:0] flags);
        t_elem_req r;
        r.action = act;
        r.node   = {n3, n2, n1, n0};
        r.flag   = flags;
        elem_q.push_back(r);
    endtask

    // mostly a small pool so masks fill up and conflicts are frequent
    function automatic logic [gbec_pkg::NODE_W-1:0] pick_node();
        if ($urandom_range(0, 99) < 85) return node_pool[$urandom_range(0, POOL_SIZE - 1)];
        return gbec_pkg::NODE_W'($urandom_range(0, gbec_pkg::NODE_COUNT_DEF - 1));
    endfunction

    function automatic gbec_pkg::t_action rand_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 78) return gbec_pkg::ACT_COLOR;
        if (r < 88) return gbec_pkg::ACT_CLEAR;
        if (r < 95) return gbec_pkg::ACT_PASS;
        return gbec_pkg::ACT_NONE;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                color_exp_q.push_back(predict_coloring(cur_req));
                n_sent++;
                idle_phase = (n_sent * 3) / n_total;
            end
            if (elem_q.size() != 0 &&
                $urandom_range(0, 99) >= (idle_phase == 0 ? 14 : idle_phase == 1 ? 73 : 0)) begin
                cur_req = elem_q.pop_front();
                i_action <= cur_req.action;
                i_node_0 <= cur_req.node[0];
                i_node_1 <= cur_req.node[1];
                i_node_2 <= cur_req.node[2];
                i_node_3 <= cur_req.node[3];
                i_use_0  <= cur_req.flag[0];
                i_use_1  <= cur_req.flag[1];
                i_use_2  <= cur_req.flag[2];
                i_use_3  <= cur_req.flag[3];
                i_valid  <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_color_result e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (color_exp_q.size() == 0) begin
                    $display("%0t: unexpected result status %0d color %0d count %0d",
                             $time, o_status, o_color, o_color_count);
                    n_err++;
                end else begin
                    e = color_exp_q.pop_front();
                    if (o_status !== e.status || o_color !== e.color ||
                        o_color_count !== e.count) begin
                        $display({"%0t: mismatch expected status %0d color %0d count %0d,",
                                  " got status %0d color %0d count %0d"},
                                 $time, e.status, e.color, e.count,
                                 o_status, o_color, o_color_count);
                        n_err++;
                    end
                end
            end
            i_ready <= ($urandom_range(0, 99) >= (idle_phase == 0 ? 73 : idle_phase == 1 ? 14 : 0));
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int kind;
        int len;
        int slot;
        int j;
        int k;
        logic [gbec_pkg::NODE_W-1:0] anchor;
        logic [gbec_pkg::FIELD_REFS-1:0][gbec_pkg::NODE_W-1:0] nd;
        logic [gbec_pkg::FIELD_REFS-1:0] fl;

        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_ready  = 1'b0;
        i_action = '0;
        i_node_0 = '0;
        i_node_1 = '0;
        i_node_2 = '0;
        i_node_3 = '0;
        i_use_0  = 1'b0;
        i_use_1  = 1'b0;
        i_use_2  = 1'b0;
        i_use_3  = 1'b0;
        n_sent = 0;
        n_err = 0;
        idle_phase = 0;
        cycles = 0;
        for (k = 0; k < gbec_pkg::NODE_COUNT_DEF; k++) node_mask[k] = '0;
        pass_base   = '0;
        colors_used = '0;

        node_pool[0] = '0;
        node_pool[1] = '1;
        for (k = 2; k < POOL_SIZE; k++)
            node_pool[k] = gbec_pkg::NODE_W'($urandom_range(0, gbec_pkg::NODE_COUNT_DEF - 1));

        // directed: empty mask, duplicates, unflagged refs, clears, unused action, passes
        queue_req(gbec_pkg::ACT_COLOR, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 4'b0000);
        queue_req(gbec_pkg::ACT_COLOR, 12'h000, 12'hFFF, 12'hAAA, 12'h555, 4'b1111);
        queue_req(gbec_pkg::ACT_COLOR, 12'h000, 12'hFFF, 12'hAAA, 12'h555, 4'b1111);
        queue_req(gbec_pkg::ACT_COLOR, 12'h000, 12'h000, 12'h000, 12'h000, 4'b1111);
        queue_req(gbec_pkg::ACT_COLOR, 12'h000, 12'h009, 12'h00A, 12'h00B, 4'b0001);
        queue_req(gbec_pkg::ACT_COLOR, 12'h000, 12'hAAA, 12'h555, 12'hFFF, 4'b0110);
        queue_req(gbec_pkg::ACT_NONE,  12'h000, 12'hFFF, 12'hAAA, 12'h555, 4'b1111);
        queue_req(gbec_pkg::ACT_CLEAR, 12'h000, 12'hFFF, 12'hAAA, 12'h555, 4'b0001);
        queue_req(gbec_pkg::ACT_COLOR, 12'h000, 12'hFFF, 12'hAAA, 12'h555, 4'b0001);
        queue_req(gbec_pkg::ACT_CLEAR, 12'h000, 12'hFFF, 12'hAAA, 12'h555, 4'b0000);
        queue_req(gbec_pkg::ACT_PASS,  12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 4'b1111);
        queue_req(gbec_pkg::ACT_COLOR, 12'h000, 12'h123, 12'h456, 12'h789, 4'b0001);
        queue_req(gbec_pkg::ACT_PASS,  12'h000, 12'h000, 12'h000, 12'h000, 4'b0000);
        queue_req(gbec_pkg::ACT_COLOR, 12'h000, 12'hFFF, 12'hAAA, 12'h555, 4'b0000);
        for (k = 0; k < 33; k += 11)
            queue_req(gbec_pkg::ACT_COLOR, 12'h7FF, 12'h800, 12'h7FF, 12'h800, 4'b1001);
        queue_req(gbec_pkg::ACT_CLEAR, 12'h000, 12'hFFF, 12'hAAA, 12'h555, 4'b1111);
        queue_req(gbec_pkg::ACT_CLEAR, 12'h7FF, 12'h800, 12'h000, 12'h000, 4'b0011);

        while (elem_q.size() < ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                queue_req(rand_action(), pick_node(), pick_node(), pick_node(), pick_node(),
                          4'($urandom));
            end else if (kind < 63) begin
                // repeatedly color through one node to fill its mask, possibly until it runs out of colors
                anchor = node_pool[$urandom_range(0, POOL_SIZE - 1)];
                slot   = $urandom_range(0, gbec_pkg::FIELD_REFS - 1);
                len    = $urandom_range(20, 34);
                for (j = 0; j < len; j++) begin
                    for (k = 0; k < gbec_pkg::FIELD_REFS; k++) nd[k] = pick_node();
                    nd[slot] = anchor;
                    fl = 4'($urandom);
                    fl[slot] = 1'b1;
                    queue_req(gbec_pkg::ACT_COLOR, nd[0], nd[1], nd[2], nd[3], fl);
                end
            end else if (kind < 75) begin
                len = $urandom_range(1, 4);
                for (j = 0; j < len; j++)
                    queue_req(gbec_pkg::ACT_CLEAR, pick_node(), pick_node(), pick_node(),
                              pick_node(), 4'b1111);
            end else if (kind < 77) begin
                len = $urandom_range(2, 5);
                for (j = 0; j < len; j++)
                    queue_req(gbec_pkg::ACT_PASS, pick_node(), pick_node(), pick_node(),
                              pick_node(), 4'($urandom));
            end else if (kind < 89) begin
                len = $urandom_range(4, 10);
                for (j = 0; j < len; j++)
                    queue_req(gbec_pkg::ACT_COLOR, pick_node(), pick_node(), pick_node(),
                              pick_node(), 4'b1111);
            end else begin
                // noise: any address, any action code
                queue_req(gbec_pkg::t_action'($urandom_range(0, 3)),
                          gbec_pkg::NODE_W'($urandom), gbec_pkg::NODE_W'($urandom),
                          gbec_pkg::NODE_W'($urandom), gbec_pkg::NODE_W'($urandom),
                          4'($urandom));
            end
        end
        n_total = elem_q.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent < n_total || color_exp_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_err == 0 && color_exp_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
